### src/ede_pkg.sv
`timescale 1ns / 1ps

package ede_pkg;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_CMP    = 2'd1,
        OP_FINISH = 2'd2
    } t_op;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_DRAIN = 1'b1
    } t_state;

    // Control part of a token that travels along the cell chain.
    typedef struct packed {
        logic valid;
        logic finish;
    } t_tok_ctl;

endpackage

### src/ede_cell.sv
`timescale 1ns / 1ps

module ede_cell import ede_pkg::*; #(
    parameter int CW  = 7,
    parameter int IDX = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_clear,
    input  logic          i_load_en,
    input  logic [CW-1:0] i_load_idx,
    input  logic [7:0]    i_load_sym,
    input  logic [CW-1:0] i_ref_cnt,
    input  t_tok_ctl      i_ctl,
    input  logic [7:0]    i_sym,
    input  logic [CW-1:0] i_left,
    input  logic [CW-1:0] i_diag,
    output t_tok_ctl      o_ctl,
    output logic [7:0]    o_sym,
    output logic [CW-1:0] o_left,
    output logic [CW-1:0] o_diag
);

    logic [7:0]    r_ref;
    logic [CW-1:0] r_cost;
    logic [CW-1:0] n_cost;
    t_tok_ctl      r_ctl;
    logic [7:0]    r_sym;
    logic [CW-1:0] r_left;
    logic [CW-1:0] r_diag;
    logic [CW-1:0] n_left;
    logic [CW-1:0] n_diag;
    logic          w_active;
    logic [CW:0]   w_up;
    logic [CW:0]   w_lf;
    logic [CW:0]   w_sub;
    logic [CW:0]   w_min;

    // Cells past the end of the reference string just pass tokens along.
    assign w_active = CW'(IDX) <= i_ref_cnt;

    always_comb begin
        w_up  = {1'b0, r_cost} + (CW+1)'(1);
        w_lf  = {1'b0, i_left} + (CW+1)'(1);
        w_sub = {1'b0, i_diag} + (CW+1)'(r_ref != i_sym);
        w_min = (w_up < w_lf) ? w_up : w_lf;
        if (w_sub < w_min) begin
            w_min = w_sub;
        end
    end

    always_comb begin
        n_cost = r_cost;
        n_left = i_left;
        n_diag = i_diag;
        if (i_ctl.valid && w_active) begin
            if (i_ctl.finish) begin
                n_left = r_cost;
            end else begin
                n_cost = CW'(w_min);
                n_left = CW'(w_min);
                n_diag = r_cost;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_cost <= CW'(IDX);
        end else begin
            r_cost <= n_cost;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load_en && (i_load_idx == CW'(IDX - 1))) begin
            r_ref <= i_load_sym;
        end
        r_sym  <= i_sym;
        r_left <= n_left;
        r_diag <= n_diag;
    end

    assign o_ctl  = r_ctl;
    assign o_sym  = r_sym;
    assign o_left = r_left;
    assign o_diag = r_diag;

endmodule

### src/edit_distance_engine.sv
`timescale 1ns / 1ps
// Load and compare items are taken one per cycle while the input is not stalled; each
// received byte moves through a chain of MAX_LEN cells, one cell per cycle, as a
// diagonal wavefront. A finish item stalls the input while its token drains the
// chain; the result is registered when the token leaves the last cell.
// A finish is also held off while the previous result still waits for its transfer.
// Synchronous active-low reset clears counts and error flag, sets cell costs to IDX.

module edit_distance_engine import ede_pkg::*; #(
    parameter int MAX_LEN = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_symbol,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [6:0] o_distance,
    output logic [6:0] o_reference_length,
    output logic [6:0] o_received_length,
    output logic       o_error_flag
);

    localparam int CW = $clog2(MAX_LEN + 1);

    t_op           w_op;
    logic          w_acc;
    logic          w_load_ok;
    logic          w_cmp_ok;
    logic          w_drop;
    logic          w_fin_acc;
    logic          w_done;

    t_state        r_state;
    t_state        n_state;
    logic [CW-1:0] r_ref_cnt;
    logic [CW-1:0] r_rec_cnt;
    logic          r_err;

    t_tok_ctl      r_inj_ctl;
    logic [7:0]    r_inj_sym;
    logic [CW-1:0] r_inj_left;
    logic [CW-1:0] r_inj_diag;

    t_tok_ctl      w_ctl  [0:MAX_LEN];
    logic [7:0]    w_sym  [0:MAX_LEN];
    logic [CW-1:0] w_left [0:MAX_LEN];
    logic [CW-1:0] w_diag [0:MAX_LEN];

    logic          r_out_valid;
    logic [CW-1:0] r_out_dist;
    logic [CW-1:0] r_out_refl;
    logic [CW-1:0] r_out_recl;
    logic          r_out_err;

    assign w_op  = t_op'(i_opcode);
    assign w_acc = i_valid && !o_stall;

    always_comb begin
        w_load_ok = 1'b0;
        w_cmp_ok  = 1'b0;
        w_drop    = 1'b0;
        w_fin_acc = 1'b0;
        if (w_acc) begin
            case (w_op)
                OP_LOAD: begin
                    if ((r_rec_cnt != '0) || (r_ref_cnt == CW'(MAX_LEN))) begin
                        w_drop = 1'b1;
                    end else begin
                        w_load_ok = 1'b1;
                    end
                end
                OP_CMP: begin
                    if (r_rec_cnt == CW'(MAX_LEN)) begin
                        w_drop = 1'b1;
                    end else begin
                        w_cmp_ok = 1'b1;
                    end
                end
                OP_FINISH: w_fin_acc = 1'b1;
                default: ;
            endcase
        end
    end

    // The finish token leaves the last cell only after every earlier wavefront.
    assign w_done = w_ctl[MAX_LEN].valid && w_ctl[MAX_LEN].finish;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (w_fin_acc) n_state = ST_DRAIN;
            ST_DRAIN: if (w_done)    n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_stall = 1'b0;
        unique case (r_state)
            ST_IDLE:  o_stall = r_out_valid && (w_op == OP_FINISH);
            ST_DRAIN: o_stall = 1'b1;
            default:  o_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_ref_cnt <= '0;
            r_rec_cnt <= '0;
            r_err     <= 1'b0;
            r_inj_ctl <= '0;
        end else begin
            r_state <= n_state;
            if (w_done) begin
                r_ref_cnt <= '0;
                r_rec_cnt <= '0;
                r_err     <= 1'b0;
            end else begin
                if (w_load_ok) r_ref_cnt <= r_ref_cnt + CW'(1);
                if (w_cmp_ok)  r_rec_cnt <= r_rec_cnt + CW'(1);
                if (w_drop)    r_err     <= 1'b1;
            end
            r_inj_ctl.valid  <= w_cmp_ok || w_fin_acc;
            r_inj_ctl.finish <= w_fin_acc;
        end
    end

    // Column zero of the cost row is simply the received count.
    always_ff @(posedge i_clk) begin
        r_inj_sym  <= i_symbol;
        r_inj_left <= w_cmp_ok ? r_rec_cnt + CW'(1) : r_rec_cnt;
        r_inj_diag <= r_rec_cnt;
    end

    assign w_ctl[0]  = r_inj_ctl;
    assign w_sym[0]  = r_inj_sym;
    assign w_left[0] = r_inj_left;
    assign w_diag[0] = r_inj_diag;

    for (genvar k = 1; k <= MAX_LEN; k++) begin : g_cell
        ede_cell #(
            .CW  (CW),
            .IDX (k)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_clear    (w_done),
            .i_load_en  (w_load_ok),
            .i_load_idx (r_ref_cnt),
            .i_load_sym (i_symbol),
            .i_ref_cnt  (r_ref_cnt),
            .i_ctl      (w_ctl[k-1]),
            .i_sym      (w_sym[k-1]),
            .i_left     (w_left[k-1]),
            .i_diag     (w_diag[k-1]),
            .o_ctl      (w_ctl[k]),
            .o_sym      (w_sym[k]),
            .o_left     (w_left[k]),
            .o_diag     (w_diag[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out_dist <= w_left[MAX_LEN];
            r_out_refl <= r_ref_cnt;
            r_out_recl <= r_rec_cnt;
            r_out_err  <= r_err;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_distance         = 7'(r_out_dist);
    assign o_reference_length = 7'(r_out_refl);
    assign o_received_length  = 7'(r_out_recl);
    assign o_error_flag       = r_out_err;

    a_done_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_state == ST_DRAIN))
        else $error("finish token left the chain outside of a drain");

    a_done_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |=> (r_out_valid && (r_ref_cnt == '0) && (r_rec_cnt == '0)))
        else $error("result not presented or block not cleared after finish");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ref_cnt <= CW'(MAX_LEN)) && (r_rec_cnt <= CW'(MAX_LEN)))
        else $error("string count beyond maximum length");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> !r_out_valid)
        else $error("result register overwritten before transfer");

endmodule
